[hw/rtl/battery_lightbar_sequencer_top_defines.svh]
// Assertion macros shared by the lightbar sequencer RTL.
`ifndef BATTERY_LIGHTBAR_SEQUENCER_TOP_DEFINES_SVH
`define BATTERY_LIGHTBAR_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BLSQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lightbar sequencer check failed");

// Next-cycle implication, checked out of reset.
`define BLSQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lightbar sequencer check failed");

`endif

[hw/rtl/blsq_pkg.sv]
// Types, constants and pattern tables for the battery lightbar sequencer.
package blsq_pkg;

   localparam int TICKS_PER_SECOND = 5;

   localparam logic [4:0] NUM_STATES   = 5'd16;
   localparam logic [4:0] STATE_NONE   = 5'd16;
   localparam logic [4:0] FIRST_AWAKE  = 5'd10;
   localparam logic [7:0] HOLD_FOREVER = 8'd255;
   localparam logic [7:0] RESUME_TICKS = 8'(3 * TICKS_PER_SECOND);
   localparam logic [7:0] BLINK_OFF_TICKS = 8'(5 * TICKS_PER_SECOND);
   localparam logic [7:0] BLINK_ON_TICKS  = 8'(1 * TICKS_PER_SECOND);

   // Lightbar state codes used by the selection logic.
   localparam logic [4:0] ST_OFF            = 5'd0;
   localparam logic [4:0] ST_LID_CLOSED     = 5'd1;
   localparam logic [4:0] ST_SLEEP_AC       = 5'd2;
   localparam logic [4:0] ST_SLEEP_AC_BATT  = 5'd3;
   localparam logic [4:0] ST_SLEEP_BATT_LOW = 5'd8;
   localparam logic [4:0] ST_SLEEP_BATT     = 5'd9;
   localparam logic [4:0] ST_AWAKE_AC       = 5'd10;
   localparam logic [4:0] ST_AWAKE_BATT     = 5'd11;

   localparam logic [2:0] COL_RESET   = 3'd0;
   localparam logic [2:0] COL_OFF     = 3'd1;
   localparam logic [2:0] COL_ORG20   = 3'd2;
   localparam logic [2:0] COL_GRN40   = 3'd3;
   localparam logic [2:0] COL_GRN60   = 3'd4;
   localparam logic [2:0] COL_GRN80   = 3'd5;
   localparam logic [2:0] COL_GRNFULL = 3'd6;
   localparam logic [2:0] COL_ORGFULL = 3'd7;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_DENIED  = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic [1:0] REG_LEVEL_ONE   = 2'd0;
   localparam logic [1:0] REG_LEVEL_TWO   = 2'd1;
   localparam logic [1:0] REG_LEVEL_THREE = 2'd2;
   localparam logic [1:0] REG_LEVEL_FOUR  = 2'd3;

   typedef enum logic [2:0] {
      CMD_TICK     = 3'd0,
      CMD_STARTUP  = 3'd1,
      CMD_SUSPEND  = 3'd2,
      CMD_RESUME   = 3'd3,
      CMD_AUTO_ON  = 3'd4,
      CMD_AUTO_OFF = 3'd5,
      CMD_DEMO     = 3'd6,
      CMD_INVALID  = 3'd7
   } cmd_type;

   typedef struct packed {
      cmd_type    command;
      logic       bar_enabled;
      logic       lid_open;
      logic       chipset_suspended;
      logic       ac_present;
      logic       battery_fitted;
      logic       charge_shown;
      logic [6:0] battery_percent;
      logic [7:0] demo_value;
   } req_type;

   typedef struct packed {
      logic       color_write;
      logic [2:0] bar_color;
      logic [1:0] status;
      logic [4:0] bar_state;
   } rsp_type;

   typedef struct packed {
      logic [6:0] level_one;
      logic [6:0] level_two;
      logic [6:0] level_three;
      logic [6:0] level_four;
   } thresh_type;

   typedef struct packed {
      logic       auto_mode;
      logic [4:0] demo_state;
      logic [4:0] current_state;
      logic [7:0] phase_count;
      logic [7:0] pattern_period;
      logic       debounce_left;
      logic [7:0] resume_count;
      logic       sleep_seen;
   } state_type;

   localparam logic [6:0] LEVEL_ONE_RESET   = 7'd16;
   localparam logic [6:0] LEVEL_TWO_RESET   = 7'd40;
   localparam logic [6:0] LEVEL_THREE_RESET = 7'd60;
   localparam logic [6:0] LEVEL_FOUR_RESET  = 7'd80;

   // Length of the first phase of a state's pattern.
   function automatic logic [7:0] pattern_ticks0(input logic [3:0] st);
      logic [7:0] t;
      t = (st == ST_SLEEP_BATT_LOW[3:0]) ? BLINK_OFF_TICKS : HOLD_FOREVER;
      return t;
   endfunction

   // Whole pattern length, both phases, wrapped to eight bits.
   function automatic logic [7:0] pattern_len(input logic [3:0] st);
      logic [7:0] t;
      t = (st == ST_SLEEP_BATT_LOW[3:0]) ? 8'(BLINK_OFF_TICKS + BLINK_ON_TICKS)
                                         : HOLD_FOREVER;
      return t;
   endfunction

   function automatic logic [2:0] pattern_color(input logic [3:0] st, input logic ph);
      logic [2:0] c;
      if (ph) begin
         c = (st == ST_SLEEP_BATT_LOW[3:0]) ? COL_ORGFULL : COL_RESET;
      end else begin
         unique case (st)
            4'd3, 4'd11: c = COL_ORG20;
            4'd4, 4'd12: c = COL_GRN40;
            4'd5, 4'd13: c = COL_GRN60;
            4'd6, 4'd14: c = COL_GRN80;
            4'd7, 4'd15: c = COL_GRNFULL;
            default:     c = COL_OFF;
         endcase
      end
      return c;
   endfunction

endpackage

[hw/rtl/battery_lightbar_sequencer_top.sv]
// Top level of the battery lightbar sequencer: CSRs, state and result register.
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle; req_ready drops only while a result waits
// in the single output register and rsp_ready is low.
// Reset is synchronous: thresholds return to 16/40/60/80, sequencer state to
// auto mode off, no current state, and the output register empties.
`include "battery_lightbar_sequencer_top_defines.svh"

module battery_lightbar_sequencer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  blsq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output blsq_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   blsq_pkg::state_type  state_ff;
   blsq_pkg::state_type  state_in;
   blsq_pkg::thresh_type thresh_ff;
   blsq_pkg::rsp_type    rsp_ff;
   blsq_pkg::rsp_type    rsp_in;
   logic                 rsp_valid_ff;
   logic                 req_fire;
   logic                 csr_write;
   logic [6:0]           csr_rd;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   blsq_step u_step (
      .req      (req_data),
      .state    (state_ff),
      .thresh   (thresh_ff),
      .state_in (state_in),
      .rsp      (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.level_one   <= blsq_pkg::LEVEL_ONE_RESET;
         thresh_ff.level_two   <= blsq_pkg::LEVEL_TWO_RESET;
         thresh_ff.level_three <= blsq_pkg::LEVEL_THREE_RESET;
         thresh_ff.level_four  <= blsq_pkg::LEVEL_FOUR_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            blsq_pkg::REG_LEVEL_ONE:   thresh_ff.level_one   <= pwdata[6:0];
            blsq_pkg::REG_LEVEL_TWO:   thresh_ff.level_two   <= pwdata[6:0];
            blsq_pkg::REG_LEVEL_THREE: thresh_ff.level_three <= pwdata[6:0];
            blsq_pkg::REG_LEVEL_FOUR:  thresh_ff.level_four  <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         blsq_pkg::REG_LEVEL_ONE:   csr_rd = thresh_ff.level_one;
         blsq_pkg::REG_LEVEL_TWO:   csr_rd = thresh_ff.level_two;
         blsq_pkg::REG_LEVEL_THREE: csr_rd = thresh_ff.level_three;
         blsq_pkg::REG_LEVEL_FOUR:  csr_rd = thresh_ff.level_four;
         default:                   csr_rd = 7'd0;
      endcase
   end

   assign prdata = {25'd0, csr_rd};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.auto_mode      <= 1'b0;
         state_ff.demo_state     <= blsq_pkg::ST_OFF;
         state_ff.current_state  <= blsq_pkg::STATE_NONE;
         state_ff.phase_count    <= 8'd0;
         state_ff.pattern_period <= 8'd0;
         state_ff.debounce_left  <= 1'b0;
         state_ff.resume_count   <= 8'd0;
         state_ff.sleep_seen     <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         if (req_fire) begin
            state_ff <= state_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BLSQ_ASSERT_NEXT(a_fire_gives_result, clock, reset, req_fire, rsp_valid)
   `BLSQ_ASSERT_NOW(a_no_write_no_color, clock, reset,
      rsp_valid && !rsp_data.color_write,
      rsp_data.bar_color == blsq_pkg::COL_RESET)
   `BLSQ_ASSERT_NEXT(a_state_stays_set, clock, reset,
      state_ff.current_state != blsq_pkg::STATE_NONE,
      state_ff.current_state != blsq_pkg::STATE_NONE)
   `BLSQ_ASSERT_NOW(a_bad_status_no_write, clock, reset,
      rsp_valid && rsp_data.status != blsq_pkg::STATUS_OK,
      !rsp_data.color_write)

endmodule

[hw/rtl/blsq_step.sv]
// Next-state and result logic for one item of the lightbar sequencer.
module blsq_step (
   input  blsq_pkg::req_type    req,
   input  blsq_pkg::state_type  state,
   input  blsq_pkg::thresh_type thresh,
   output blsq_pkg::state_type  state_in,
   output blsq_pkg::rsp_type    rsp
);

   logic [2:0] level;
   logic       batt;
   logic [4:0] want_auto;
   logic [4:0] want_manual;
   logic [4:0] want;
   logic       ph;
   logic [8:0] phase_next;
   logic       wr;
   logic [2:0] col;
   logic [1:0] st_code;

   always_comb begin
      priority if (req.battery_percent < thresh.level_one)   level = 3'd0;
      else if     (req.battery_percent < thresh.level_two)   level = 3'd1;
      else if     (req.battery_percent < thresh.level_three) level = 3'd2;
      else if     (req.battery_percent < thresh.level_four)  level = 3'd3;
      else                                                   level = 3'd4;
   end

   assign batt = req.battery_fitted & req.charge_shown;

   always_comb begin
      priority if (!req.lid_open) begin
         want_auto = blsq_pkg::ST_LID_CLOSED;
      end else if (state.resume_count != 8'd0) begin
         want_auto = batt ? 5'(blsq_pkg::ST_AWAKE_BATT + {2'b00, level})
                          : blsq_pkg::ST_AWAKE_AC;
      end else if (!req.chipset_suspended) begin
         want_auto = blsq_pkg::ST_OFF;
      end else if (req.ac_present) begin
         want_auto = batt ? 5'(blsq_pkg::ST_SLEEP_AC_BATT + {2'b00, level})
                          : blsq_pkg::ST_SLEEP_AC;
      end else begin
         want_auto = (req.battery_percent < thresh.level_one) ?
                     blsq_pkg::ST_SLEEP_BATT_LOW : blsq_pkg::ST_SLEEP_BATT;
      end
   end

   // An awake demo state only shows while the resume countdown runs.
   always_comb begin
      want_manual = state.demo_state;
      if (state.demo_state != blsq_pkg::STATE_NONE &&
          state.demo_state >= blsq_pkg::FIRST_AWAKE &&
          state.resume_count == 8'd0) begin
         want_manual = blsq_pkg::ST_OFF;
      end
   end

   assign want = state.auto_mode ? want_auto : want_manual;

   always_comb begin
      state_in   = state;
      wr         = 1'b0;
      col        = blsq_pkg::COL_RESET;
      st_code    = blsq_pkg::STATUS_OK;
      ph         = 1'b0;
      phase_next = 9'd0;
      unique case (req.command)
         blsq_pkg::CMD_TICK: begin
            if (req.bar_enabled && !(!state.auto_mode && want >= blsq_pkg::NUM_STATES)) begin
               if (state.resume_count != 8'd0) begin
                  state_in.resume_count = state.resume_count - 8'd1;
               end
               if (want != state.current_state) begin
                  state_in.current_state  = want;
                  state_in.phase_count    = 8'd0;
                  state_in.pattern_period = blsq_pkg::pattern_len(want[3:0]);
                  state_in.debounce_left  = 1'b1;
               end
               if (state_in.pattern_period == 8'd0 || state_in.current_state[4]) begin
                  wr  = 1'b1;
                  col = blsq_pkg::COL_OFF;
               end else if (state_in.debounce_left) begin
                  state_in.debounce_left = 1'b0;
               end else begin
                  ph = (state_in.phase_count >=
                        blsq_pkg::pattern_ticks0(state_in.current_state[3:0]));
                  phase_next = {1'b0, state_in.phase_count} + 9'd1;
                  state_in.phase_count = (phase_next >= {1'b0, state_in.pattern_period}) ?
                                         8'd0 : phase_next[7:0];
                  wr  = 1'b1;
                  col = blsq_pkg::pattern_color(state_in.current_state[3:0], ph);
               end
            end
         end
         blsq_pkg::CMD_STARTUP: begin
            if (req.bar_enabled) begin
               state_in.sleep_seen   = 1'b0;
               state_in.resume_count = 8'd0;
               wr = 1'b1;
            end
         end
         blsq_pkg::CMD_SUSPEND: begin
            if (req.bar_enabled) begin
               state_in.auto_mode    = 1'b1;
               state_in.sleep_seen   = 1'b1;
               state_in.resume_count = 8'd0;
               wr = 1'b1;
            end
         end
         blsq_pkg::CMD_RESUME: begin
            if (req.bar_enabled) begin
               state_in.auto_mode    = 1'b1;
               state_in.resume_count = state.sleep_seen ? blsq_pkg::RESUME_TICKS : 8'd0;
               state_in.sleep_seen   = 1'b0;
            end
         end
         blsq_pkg::CMD_AUTO_ON: begin
            state_in.auto_mode = 1'b1;
         end
         blsq_pkg::CMD_AUTO_OFF: begin
            state_in.auto_mode    = 1'b0;
            state_in.demo_state   = blsq_pkg::STATE_NONE;
            state_in.resume_count = 8'd0;
         end
         blsq_pkg::CMD_DEMO: begin
            if (state.auto_mode) begin
               st_code = blsq_pkg::STATUS_DENIED;
            end else if (req.demo_value >= {3'b000, blsq_pkg::NUM_STATES}) begin
               state_in.demo_state   = blsq_pkg::STATE_NONE;
               state_in.resume_count = 8'd0;
            end else begin
               state_in.demo_state = req.demo_value[4:0];
               if (req.demo_value[4:0] >= blsq_pkg::FIRST_AWAKE) begin
                  state_in.resume_count = blsq_pkg::RESUME_TICKS;
               end
            end
         end
         blsq_pkg::CMD_INVALID: begin
            st_code = blsq_pkg::STATUS_INVALID;
         end
         default: begin
            st_code = blsq_pkg::STATUS_INVALID;
         end
      endcase
   end

   assign rsp.color_write = wr;
   assign rsp.bar_color   = col;
   assign rsp.status      = st_code;
   assign rsp.bar_state   = state_in.current_state;

endmodule
